### rtl/signed_int_to_radix_digits_assert.svh
// Assertion macros used by the top level of the radix digit converter.
`ifndef SIGNED_INT_TO_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("signed_int_to_radix_digits: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("signed_int_to_radix_digits: next-cycle check failed");

`endif

### rtl/srd_pkg.sv
// Types and constants of the radix digit converter.
`default_nettype none

package srd_pkg;

  localparam int unsigned NUM_W     = 32;
  localparam int unsigned BASE_W    = 5;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned TBL_DEPTH = 16;
  localparam int unsigned STK_DEPTH = 32;
  localparam int unsigned STK_AW    = 5;
  localparam int unsigned DEPTH_W   = 6;
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_STEPS = NUM_W / DIV_BITS;
  localparam int unsigned STEP_W    = 3;

  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_RD,
    S_CHK_CMP,
    S_SIGN,
    S_DIV_GO,
    S_DIV_WAIT,
    S_POP_RD,
    S_POP_TBL,
    S_POP_OUT
  } srd_state_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  dividend;
    logic [BASE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [NUM_W-1:0]  quot;
    logic [BASE_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [SYM_W-1:0] sym;
  } alpha_wr_t;

endpackage

`default_nettype wire

### rtl/srd_ifs.sv
// Channel interfaces of the radix digit converter: input items, results, configuration.
`default_nettype none

interface srd_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  symbol_index;
  logic [7:0]  symbol_char;
  logic signed [31:0] number;

  modport source (output valid, req_type, symbol_index, symbol_char, number, input ready);
  modport sink   (input valid, req_type, symbol_index, symbol_char, number, output ready);
endinterface

interface srd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

interface srd_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] radix;

  modport source (output valid, radix, input ready);
  modport sink   (input valid, radix, output ready);
endinterface

`default_nettype wire

### rtl/signed_int_to_radix_digits.sv
// Top level of the signed integer to radix digit converter.
//
//   channel  | dir | payload                                        | beat when
//   in_ch    | in  | req_type, symbol_index, symbol_char, number    | valid & ready
//   out_ch   | out | out_char, last                                 | valid & ready
//   cfg_ch   | in  | radix                                          | valid & ready
//
// A load item writes the table while idle. A convert item scans the alphabet
// (read, then compare, per entry), runs the divider once per digit, then sends
// each character through the digit stack and table, with a leading minus sign.
// Reset is synchronous and clears the sequencer, the radix and the output valid.
// A stalled result holds the sequencer at its emit step; in_ch is ready only when idle.
`default_nettype none

module signed_int_to_radix_digits import srd_pkg::*; #(
  parameter int unsigned MAX_BASE = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  srd_in_if.sink   in_ch,
  srd_out_if.source out_ch,
  srd_cfg_if.sink  cfg_ch
);

`include "signed_int_to_radix_digits_assert.svh"

  localparam logic [BASE_W-1:0] BASE_LIM =
    (MAX_BASE < TBL_DEPTH) ? BASE_W'(MAX_BASE) : BASE_W'(TBL_DEPTH);
  localparam logic [DEPTH_W-1:0] DEPTH_LAST = DEPTH_W'(STK_DEPTH - 1);

  srd_state_t         state_r;
  srd_state_t         state_nxt;
  logic [BASE_W-1:0]  radix_r;
  logic [NUM_W-1:0]   mag_r;
  logic               neg_r;
  logic [IDX_W-1:0]   pos_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [IDX_W-1:0]   stk_q_r;
  logic               out_valid_r;
  logic [SYM_W-1:0]   out_char_r;
  logic               out_last_r;
  logic [IDX_W-1:0]   stk_mem [STK_DEPTH];

  logic               in_acc;
  logic               base_ok;
  logic               out_free;
  logic               sym_bad;
  logic               chk_end;
  logic               more_digits;
  logic [DEPTH_W-1:0] depth_dec;
  logic [NUM_W-1:0]   num_u;

  // Decoded controls.
  logic               in_rdy;
  logic               out_load;
  logic [SYM_W-1:0]   out_char_nxt;
  logic               out_last_nxt;
  logic               stk_we;
  logic               stk_re;
  logic [IDX_W-1:0]   rd_idx;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  alpha_wr_t          alpha_wr;
  logic [SYM_W-1:0]   rd_sym;
  logic               dup;

  srd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  srd_alpha u_alpha (
    .clk      (clk),
    .wr       (alpha_wr),
    .rd_idx   (rd_idx),
    .chk_pos  (pos_r),
    .radix    (radix_r),
    .rd_sym   (rd_sym),
    .dup      (dup)
  );

  assign in_acc      = in_ch.valid && in_rdy;
  assign base_ok     = (radix_r >= BASE_W'(2)) && (radix_r <= BASE_LIM);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign sym_bad     = (rd_sym == CHAR_PLUS) || (rd_sym == CHAR_MINUS) || dup;
  assign chk_end     = ({1'b0, pos_r} == (radix_r - 1'b1));
  assign more_digits = (div_rsp.quot != '0) && (depth_r != DEPTH_LAST);
  assign depth_dec   = depth_r - 1'b1;
  assign num_u       = in_ch.number;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.req_type == REQ_CONVERT) && base_ok) begin
          state_nxt = S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        state_nxt = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        if (sym_bad) begin
          state_nxt = S_IDLE;
        end else if (chk_end) begin
          state_nxt = neg_r ? S_SIGN : S_DIV_GO;
        end else begin
          state_nxt = S_CHK_RD;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = more_digits ? S_DIV_GO : S_POP_RD;
        end
      end
      S_POP_RD: begin
        state_nxt = S_POP_TBL;
      end
      S_POP_TBL: begin
        state_nxt = S_POP_OUT;
      end
      S_POP_OUT: begin
        if (out_free) begin
          state_nxt = (depth_r == '0) ? S_IDLE : S_POP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_rdy           = 1'b0;
    out_load         = 1'b0;
    out_char_nxt     = rd_sym;
    out_last_nxt     = 1'b0;
    stk_we           = 1'b0;
    stk_re           = 1'b0;
    rd_idx           = stk_q_r;
    div_req.start    = 1'b0;
    div_req.dividend = mag_r;
    div_req.divisor  = radix_r;
    alpha_wr.en      = 1'b0;
    alpha_wr.idx     = in_ch.symbol_index;
    alpha_wr.sym     = in_ch.symbol_char;
    case (state_r)
      S_IDLE: begin
        in_rdy      = 1'b1;
        alpha_wr.en = in_ch.valid && (in_ch.req_type == REQ_LOAD);
      end
      S_CHK_RD: begin
        rd_idx = pos_r;
      end
      S_SIGN: begin
        out_load     = out_free;
        out_char_nxt = CHAR_MINUS;
      end
      S_DIV_GO: begin
        div_req.start = 1'b1;
      end
      S_DIV_WAIT: begin
        stk_we = div_rsp.done;
      end
      S_POP_RD: begin
        stk_re = 1'b1;
      end
      S_POP_OUT: begin
        out_load     = out_free;
        out_last_nxt = (depth_r == '0);
      end
      default: begin
        in_rdy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radix_r     <= '0;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        radix_r <= cfg_ch.radix;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        depth_r <= '0;
      end else if (stk_we) begin
        depth_r <= depth_r + 1'b1;
      end else if (stk_re) begin
        depth_r <= depth_dec;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      neg_r <= num_u[NUM_W-1];
      mag_r <= num_u[NUM_W-1] ? (NUM_W'(0) - num_u) : num_u;
      pos_r <= '0;
    end else if (stk_we) begin
      mag_r <= div_rsp.quot;
    end
    if ((state_r == S_CHK_CMP) && !sym_bad) begin
      pos_r <= pos_r + 1'b1;
    end
    if (out_load) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // Digit stack: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[depth_r[STK_AW-1:0]] <= div_rsp.rem[IDX_W-1:0];
    end
    if (stk_re) begin
      stk_q_r <= stk_mem[depth_dec[STK_AW-1:0]];
    end
  end

  assign in_ch.ready     = in_rdy;
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.last     = out_last_r;

  `SRD_ASSERT_IMP(a_div_done_in_wait, div_rsp.done, state_r == S_DIV_WAIT)
  `SRD_ASSERT_NXT(a_push_grows_depth, stk_we, depth_r == $past(depth_r) + 1'b1)
  `SRD_ASSERT_NXT(a_bad_base_no_work,
                  in_acc && (in_ch.req_type == REQ_CONVERT) && !base_ok,
                  state_r == S_IDLE)

endmodule

`default_nettype wire

### rtl/srd_div.sv
// Iterative divider: 32-bit magnitude by a small radix, four quotient bits per cycle.
`default_nettype none

module srd_div import srd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [NUM_W-1:0]  quo_r;
  logic [BASE_W-1:0] rem_r;
  logic [BASE_W-1:0] dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [NUM_W-1:0]  quo_nxt;
  logic [BASE_W-1:0] rem_nxt;

  // Restoring division, unrolled over a few narrow steps.
  always_comb begin
    logic [BASE_W:0] t;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    t       = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      t       = {rem_nxt, quo_nxt[NUM_W-1]};
      quo_nxt = {quo_nxt[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        t          = t - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = t[BASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        done_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r  <= cnt_r + 1'b1;
        done_r <= (cnt_r == STEP_W'(DIV_STEPS - 1));
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

### rtl/srd_alpha.sv
// Alphabet table with one registered read port and a duplicate-symbol compare.
`default_nettype none

module srd_alpha import srd_pkg::*; (
  input  logic              clk,
  input  alpha_wr_t         wr,
  input  logic [IDX_W-1:0]  rd_idx,
  input  logic [IDX_W-1:0]  chk_pos,
  input  logic [BASE_W-1:0] radix,
  output logic [SYM_W-1:0]  rd_sym,
  output logic              dup
);

  logic [SYM_W-1:0] tbl_r [TBL_DEPTH];
  logic [SYM_W-1:0] rd_sym_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      tbl_r[wr.idx] <= wr.sym;
    end
    rd_sym_r <= tbl_r[rd_idx];
  end

  // The symbol just read at chk_pos is compared against every later symbol in use.
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < TBL_DEPTH; j++) begin
      if ((BASE_W'(j) > {1'b0, chk_pos}) && (BASE_W'(j) < radix) &&
          (tbl_r[IDX_W'(j)] == rd_sym_r)) begin
        dup = 1'b1;
      end
    end
  end

  assign rd_sym = rd_sym_r;

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// Testbench of the radix digit converter: directed and random items checked by a scoreboard.

module testbench import srd_pkg::*; ();

  localparam int unsigned RADIX_MAX   = 16;
  localparam int unsigned SETTLE_CYC  = 600;
  localparam int unsigned HOLD_CYC    = 500;
  localparam int unsigned DRAIN_LIMIT = 50000;
  localparam int unsigned NUM_PHASES  = 12;
  localparam logic [BASE_W-1:0] RADIX_PLAN [NUM_PHASES] = '{
    5'd16, 5'd2, 5'd10, 5'd0, 5'd7, 5'd16, 5'd3, 5'd1, 5'd2, 5'd16, 5'd5, 5'd13
  };

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] symbol_index;
    logic [SYM_W-1:0] symbol_char;
    logic [NUM_W-1:0] number;
  } radix_req_t;

  typedef struct packed {
    logic [SYM_W-1:0] ch;
    logic             last;
  } digit_beat_t;

  class digit_scoreboard;
    logic [SYM_W-1:0]  sym_tab [TBL_DEPTH];
    logic [BASE_W-1:0] radix;
    digit_beat_t       want_q [$];
    int unsigned       mismatches;

    function new();
      foreach (sym_tab[i]) sym_tab[i] = '0;
      radix = '0;
      mismatches = 0;
    endfunction

    function bit alphabet_usable();
      int i;
      int j;
      if (radix < 2 || radix > RADIX_MAX) return 1'b0;
      for (i = 0; i < radix; i++) begin
        if (sym_tab[i] == CHAR_PLUS || sym_tab[i] == CHAR_MINUS) return 1'b0;
        for (j = i + 1; j < radix; j++)
          if (sym_tab[j] == sym_tab[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Works out the character beats that one accepted item causes.
    function void note_item(radix_req_t it);
      logic [NUM_W-1:0] mag;
      logic [3:0]       digits [STK_DEPTH];
      digit_beat_t      beat;
      int               nd;
      int               k;
      if (it.req_type == REQ_LOAD) begin
        sym_tab[it.symbol_index] = it.symbol_char;
        return;
      end
      if (!alphabet_usable()) return;
      mag = it.number;
      if (mag[NUM_W-1]) begin
        // The most negative value wraps onto its own magnitude as an unsigned number.
        mag = -mag;
        beat.ch = CHAR_MINUS;
        beat.last = 1'b0;
        want_q.push_back(beat);
      end
      nd = 0;
      do begin
        digits[nd] = 4'(mag % radix);
        mag = mag / radix;
        nd++;
      end while (mag != 0 && nd < STK_DEPTH);
      for (k = nd - 1; k >= 0; k--) begin
        beat.ch = sym_tab[digits[k]];
        beat.last = (k == 0);
        want_q.push_back(beat);
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_beat(logic [SYM_W-1:0] ch, logic last);
      digit_beat_t want;
      if (want_q.size() == 0) begin
        flag($sformatf("unexpected beat char=%02h last=%0b", ch, last));
        return;
      end
      want = want_q.pop_front();
      if (ch !== want.ch || last !== want.last)
        flag($sformatf("char exp %02h got %02h, last exp %0b got %0b",
                       want.ch, ch, want.last, last));
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  bit              pressure_go;
  bit              pressure_done = 1'b0;
  int unsigned     hold_left = 0;
  digit_scoreboard sb;

  srd_in_if  in_ch ();
  srd_out_if out_ch ();
  srd_cfg_if cfg_ch ();

  signed_int_to_radix_digits u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (pressure_go && !pressure_done) begin
      out_ch.ready <= 1'b0;
      hold_left <= HOLD_CYC;
      pressure_done <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_beat(out_ch.out_char, out_ch.last);
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer_item(input radix_req_t it);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= it.req_type;
    in_ch.symbol_index <= it.symbol_index;
    in_ch.symbol_char  <= it.symbol_char;
    in_ch.number       <= it.number;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic send_load(input logic [IDX_W-1:0] idx, input logic [SYM_W-1:0] ch);
    radix_req_t it;
    it.req_type = REQ_LOAD;
    it.symbol_index = idx;
    it.symbol_char = ch;
    it.number = $urandom();
    offer_item(it);
  endtask

  task automatic send_convert(input logic [NUM_W-1:0] num);
    radix_req_t it;
    it.req_type = REQ_CONVERT;
    it.symbol_index = IDX_W'($urandom_range(TBL_DEPTH - 1, 0));
    it.symbol_char = SYM_W'($urandom_range(255, 0));
    it.number = num;
    offer_item(it);
  endtask

  task automatic set_radix(input logic [BASE_W-1:0] r);
    cfg_ch.valid <= 1'b1;
    cfg_ch.radix <= r;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.radix = r;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Loads and rejected conversions give no beat, so after the queue drains the
  // block may still be busy; wait out a worst-case conversion as well.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (sb.want_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  function automatic int find_broken_entry();
    int i;
    int j;
    for (i = 0; i < TBL_DEPTH; i++) begin
      if (sb.sym_tab[i] == CHAR_PLUS || sb.sym_tab[i] == CHAR_MINUS) return i;
      for (j = 0; j < i; j++)
        if (sb.sym_tab[j] == sb.sym_tab[i]) return i;
    end
    return -1;
  endfunction

  // A symbol that keeps all sixteen entries distinct and free of sign characters.
  function automatic logic [SYM_W-1:0] fresh_char(input logic [IDX_W-1:0] idx);
    logic [SYM_W-1:0] c;
    bit               clash;
    int               j;
    do begin
      c = SYM_W'($urandom_range(255, 0));
      clash = (c == CHAR_PLUS || c == CHAR_MINUS);
      for (j = 0; j < TBL_DEPTH; j++)
        if (j != idx && sb.sym_tab[j] == c) clash = 1'b1;
    end while (clash);
    return c;
  endfunction

  function automatic radix_req_t random_item();
    radix_req_t  it;
    int          broken;
    int unsigned pick;
    it.symbol_index = IDX_W'($urandom_range(TBL_DEPTH - 1, 0));
    it.symbol_char = SYM_W'($urandom_range(255, 0));
    it.number = $urandom();
    if ($urandom_range(99, 0) < 20) begin
      // Most loads keep the alphabet usable or repair it; the rest are noise.
      it.req_type = REQ_LOAD;
      broken = find_broken_entry();
      if (broken >= 0 && $urandom_range(3, 0) != 0) it.symbol_index = IDX_W'(broken);
      if ($urandom_range(99, 0) < 85) it.symbol_char = fresh_char(it.symbol_index);
    end else begin
      it.req_type = REQ_CONVERT;
      pick = $urandom_range(99, 0);
      if (pick < 25) begin
        it.number = NUM_W'($urandom_range(80, 0)) - 32'd40;
      end else if (pick < 40) begin
        case ($urandom_range(5, 0))
          0: it.number = 32'h8000_0000;
          1: it.number = 32'h7FFF_FFFF;
          2: it.number = 32'h0000_0000;
          3: it.number = 32'hFFFF_FFFF;
          4: it.number = 32'h8000_0001;
          default: it.number = 32'h0000_0001;
        endcase
      end
    end
    return it;
  endfunction

  initial begin
    int unsigned      phase;
    int unsigned      count;
    int               i;
    logic [SYM_W-1:0] ch;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_LOAD;
    in_ch.symbol_index = '0;
    in_ch.symbol_char = '0;
    in_ch.number = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.radix = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_go = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Radix below two is rejected before the table is read.
    set_radix(5'd0);
    send_convert(32'd77);
    // Entry 0 is a zero byte and entry 15 is all ones; both are ordinary symbols.
    for (i = 0; i < TBL_DEPTH; i++) begin
      if (i == 0) ch = 8'h00;
      else if (i == TBL_DEPTH - 1) ch = 8'hFF;
      else if (i < 10) ch = 8'h30 + SYM_W'(i);
      else ch = 8'h37 + SYM_W'(i);
      send_load(IDX_W'(i), ch);
    end
    settle();
    set_radix(5'd1);
    send_convert(32'hFFFF_FFF0);
    settle();
    set_radix(5'd16);
    send_convert(32'h0000_0000);
    send_convert(32'h8000_0000);
    send_convert(32'h7FFF_FFFF);
    settle();
    set_radix(5'd2);
    send_convert(32'h8000_0000);
    // Sign characters and a repeated symbol each make the alphabet unusable.
    send_load(4'd1, CHAR_MINUS);
    send_convert(32'd5);
    send_load(4'd1, CHAR_PLUS);
    send_convert(32'd5);
    send_load(4'd1, 8'h00);
    send_convert(32'd5);
    send_load(4'd1, 8'h31);
    send_convert(32'hFFFF_FFFA);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      set_radix(RADIX_PLAN[phase]);
      send_idle_pct = (phase < 4) ? 36 : (phase < 8) ? 67 : 0;
      recv_idle_pct = (phase < 4) ? 67 : (phase < 8) ? 36 : 0;
      if (phase == 8) pressure_go = 1'b1;
      count = (RADIX_PLAN[phase] < 2) ? 10 : 31;
      repeat (count) offer_item(random_item());
    end
    settle();

    if (sb.mismatches == 0 && sb.want_q.size() == 0) begin
      $display("tb: success");
    end else begin
      if (sb.want_q.size() != 0)
        $display("%0d expected beats never arrived", sb.want_q.size());
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
